/* rtl/mast_pkg.sv */
// Shared types, widths and constants for the motor axis sync tracker.
// Used by every module of the block by scoped name; depends on nothing.
package mast_pkg;

    // Position sample width and the widths that follow from it
    localparam int SAMPLE_BITS = 10;
    localparam int TGT_W       = 10;
    localparam int ERR_W       = ((SAMPLE_BITS > TGT_W) ? SAMPLE_BITS : TGT_W) + 2;
    localparam int MAG_W       = ERR_W - 1;
    localparam int STEP_W      = 10;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int WIN_W       = 10;
    localparam int CMD_W       = 16;
    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 2;
    localparam int ACC_W       = 3;
    localparam int PROD1_W     = MAG_W + CFG_W;
    localparam int PROD_W      = PROD1_W + ACC_W;
    localparam int DIV_CNT_W   = $clog2(PROD_W);
    localparam int CMP_W       = (MAG_W > WIN_W) ? MAG_W : WIN_W;

    localparam int SAMPLE_HALF = 1 << (SAMPLE_BITS - 1);

    // Acceleration estimate: 1 + (1000 - |err|) / 250
    localparam int ACCEL_BASE  = 1000;
    localparam int ACCEL_SPAN  = 250;
    localparam int ACCEL_T1    = ACCEL_BASE - 3 * ACCEL_SPAN;
    localparam int ACCEL_T2    = ACCEL_BASE - 2 * ACCEL_SPAN;
    localparam int ACCEL_T3    = ACCEL_BASE - ACCEL_SPAN;

    // Setpoint clamp limits
    localparam logic signed [CMD_W-1:0] SETPOINT_MAX = 16'sd1000;
    localparam logic signed [CMD_W-1:0] SETPOINT_MIN = -16'sd1000;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SETPOINT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POWER    = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_STROKE_TIME  = 2'd0;
    localparam logic [IDX_W-1:0] REG_STROKE_STEPS = 2'd1;
    localparam logic [IDX_W-1:0] REG_SYNC_WINDOW  = 2'd2;
    localparam logic [IDX_W-1:0] REG_SYNC_TIMEOUT = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_STROKE_TIME  = 16'd3000;
    localparam logic [CFG_W-1:0] RST_STROKE_STEPS = 16'd900;
    localparam logic [WIN_W-1:0] RST_SYNC_WINDOW  = 10'd20;
    localparam logic [CFG_W-1:0] RST_SYNC_TIMEOUT = 16'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_DEADLINE,
        ST_FINISH
    } mast_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic calc;
        logic mul1;
        logic div_start;
        logic div_step;
        logic deadline;
        logic commit;
    } mast_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic move_needed;
        logic div_last;
        logic out_free;
    } mast_stat_t;

endpackage

/* rtl/mast_div.sv */
// Bit-serial restoring divider for the move time estimate.
// One quotient bit per step; uses widths from mast_pkg.
module mast_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         step,
    input  logic [mast_pkg::PROD_W-1:0]  dividend,
    input  logic [mast_pkg::CFG_W-1:0]   divisor,
    output logic [mast_pkg::PROD_W-1:0]  quotient,
    output logic                         last
);

    logic [mast_pkg::PROD_W-1:0]    quo_reg;
    logic [mast_pkg::CFG_W-1:0]     rem_reg;
    logic [mast_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [mast_pkg::CFG_W:0]       shifted;
    logic [mast_pkg::CFG_W:0]       diff;
    logic                           ge;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        shifted = {rem_reg, quo_reg[mast_pkg::PROD_W-1]};
        diff    = shifted - {1'b0, divisor};
        ge      = !diff[mast_pkg::CFG_W];
    end

    // Load the dividend, then shift in one quotient bit per step
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (step) begin
            quo_reg <= {quo_reg[mast_pkg::PROD_W-2:0], ge};
            rem_reg <= ge ? diff[mast_pkg::CFG_W-1:0] : shifted[mast_pkg::CFG_W-1:0];
        end
    end

    // Count the remaining steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= mast_pkg::DIV_CNT_W'(mast_pkg::PROD_W - 1);
        end else if (step && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == '0);

endmodule

/* rtl/mast_ctrl.sv */
// Controller state machine of the sync tracker.
// Sequences capture, move estimate and result commit; types from mast_pkg.
module mast_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  mast_pkg::mast_stat_t   stat,
    output mast_pkg::mast_cmd_t    cmd
);

    mast_pkg::mast_state_t state_reg;
    mast_pkg::mast_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mast_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mast_pkg::ST_IDLE: begin
                if (s_valid) state_next = mast_pkg::ST_CALC;
            end
            mast_pkg::ST_CALC: begin
                state_next = stat.move_needed ? mast_pkg::ST_MUL1 : mast_pkg::ST_FINISH;
            end
            mast_pkg::ST_MUL1: begin
                state_next = mast_pkg::ST_MUL2;
            end
            mast_pkg::ST_MUL2: begin
                state_next = mast_pkg::ST_DIV;
            end
            mast_pkg::ST_DIV: begin
                if (stat.div_last) state_next = mast_pkg::ST_DEADLINE;
            end
            mast_pkg::ST_DEADLINE: begin
                state_next = mast_pkg::ST_FINISH;
            end
            mast_pkg::ST_FINISH: begin
                if (stat.out_free) state_next = mast_pkg::ST_IDLE;
            end
            default: begin
                state_next = mast_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            mast_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            mast_pkg::ST_CALC:     cmd.calc      = 1'b1;
            mast_pkg::ST_MUL1:     cmd.mul1      = 1'b1;
            mast_pkg::ST_MUL2:     cmd.div_start = 1'b1;
            mast_pkg::ST_DIV:      cmd.div_step  = 1'b1;
            mast_pkg::ST_DEADLINE: cmd.deadline  = 1'b1;
            mast_pkg::ST_FINISH:   cmd.commit    = stat.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/mast_dp.sv */
// Datapath of the sync tracker: configuration, axis state, error and move
// estimate, output register. Uses mast_pkg and the divider mast_div.
module mast_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mast_pkg::mast_cmd_t                  cmd,
    output mast_pkg::mast_stat_t                 stat,
    input  logic [mast_pkg::FUNC_W-1:0]          s_func,
    input  logic [mast_pkg::SAMPLE_BITS-1:0]     s_position_sample,
    input  logic [mast_pkg::TIME_W-1:0]          s_now_ms,
    input  logic signed [mast_pkg::CMD_W-1:0]    s_command_value,
    input  logic                                 cfg_valid,
    input  logic [mast_pkg::IDX_W-1:0]           cfg_index,
    input  logic [mast_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mast_pkg::STEP_W-1:0]   m_step_relative,
    output logic                                 m_in_motion,
    output logic                                 m_synchronized,
    output logic                                 m_out_of_sync_event,
    output logic                                 m_drive_enable
);

    // Configuration
    logic [mast_pkg::CFG_W-1:0] stroke_time_reg;
    logic [mast_pkg::CFG_W-1:0] stroke_steps_reg;
    logic [mast_pkg::WIN_W-1:0] sync_window_reg;
    logic [mast_pkg::CFG_W-1:0] sync_timeout_reg;

    // Captured word
    logic [mast_pkg::FUNC_W-1:0]        func_reg;
    logic [mast_pkg::SAMPLE_BITS-1:0]   sample_reg;
    logic [mast_pkg::TIME_W-1:0]        now_reg;
    logic signed [mast_pkg::CMD_W-1:0]  cmd_val_reg;

    // Axis state
    logic signed [mast_pkg::TGT_W-1:0]  target_reg;
    logic signed [mast_pkg::TGT_W-1:0]  prev_target_reg;
    logic                               moving_reg;
    logic [mast_pkg::TIME_W-1:0]        deadline_reg;
    logic [mast_pkg::TIME_W-1:0]        last_sync_reg;
    logic                               sync_reg;
    logic                               enable_reg;

    // Error and estimate pipeline
    logic [mast_pkg::MAG_W-1:0]         mag_reg;
    logic [mast_pkg::STEP_W-1:0]        step_reg;
    logic [mast_pkg::PROD1_W-1:0]       prod1_reg;

    // Output register
    logic                               out_valid_reg;
    logic [mast_pkg::STEP_W-1:0]        out_step_reg;
    logic                               out_motion_reg;
    logic                               out_sync_reg;
    logic                               out_event_reg;
    logic                               out_enable_reg;

    logic signed [mast_pkg::ERR_W-1:0]  actual;
    logic signed [mast_pkg::ERR_W-1:0]  err;
    logic [mast_pkg::ERR_W-1:0]         err_adj;
    logic [mast_pkg::ERR_W-1:0]         err_half;
    logic [mast_pkg::MAG_W-1:0]         mag;
    logic [mast_pkg::ACC_W-1:0]         accel;
    logic [mast_pkg::PROD_W-1:0]        dividend;
    logic [mast_pkg::CFG_W-1:0]         divisor;
    logic [mast_pkg::PROD_W-1:0]        quotient;
    logic                               div_last;

    logic [mast_pkg::TIME_W-1:0]        past;
    logic [mast_pkg::TIME_W-1:0]        since_sync;
    logic                               moving_upd;
    logic                               in_window;
    logic                               sync_upd;
    logic                               event_upd;
    logic signed [mast_pkg::CMD_W-1:0]  clamped;
    logic [mast_pkg::CMD_W-1:0]         clamp_adj;
    logic [mast_pkg::TGT_W-1:0]         setpoint;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stroke_time_reg  <= mast_pkg::RST_STROKE_TIME;
            stroke_steps_reg <= mast_pkg::RST_STROKE_STEPS;
            sync_window_reg  <= mast_pkg::RST_SYNC_WINDOW;
            sync_timeout_reg <= mast_pkg::RST_SYNC_TIMEOUT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mast_pkg::REG_STROKE_TIME:  stroke_time_reg  <= cfg_data;
                mast_pkg::REG_STROKE_STEPS: stroke_steps_reg <= cfg_data;
                mast_pkg::REG_SYNC_WINDOW:  sync_window_reg  <= cfg_data[mast_pkg::WIN_W-1:0];
                mast_pkg::REG_SYNC_TIMEOUT: sync_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the accepted word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= s_func;
            sample_reg  <= s_position_sample;
            now_reg     <= s_now_ms;
            cmd_val_reg <= s_command_value;
        end
    end

    // Recenter the sample, take the error, its magnitude and its half
    always_comb begin
        actual   = mast_pkg::ERR_W'(sample_reg) - mast_pkg::ERR_W'(mast_pkg::SAMPLE_HALF);
        err      = mast_pkg::ERR_W'(target_reg) - actual;
        err_adj  = err + {{(mast_pkg::ERR_W-1){1'b0}}, err[mast_pkg::ERR_W-1]};
        err_half = {err_adj[mast_pkg::ERR_W-1], err_adj[mast_pkg::ERR_W-1:1]};
        mag      = err[mast_pkg::ERR_W-1] ? mast_pkg::MAG_W'(-err) : mast_pkg::MAG_W'(err);
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            mag_reg  <= mag;
            step_reg <= err_half[mast_pkg::STEP_W-1:0];
        end
    end

    // Acceleration factor from the error size
    always_comb begin
        priority if (mag_reg == '0)                                accel = 3'd5;
        else if (mag_reg <= mast_pkg::MAG_W'(mast_pkg::ACCEL_T1))  accel = 3'd4;
        else if (mag_reg <= mast_pkg::MAG_W'(mast_pkg::ACCEL_T2))  accel = 3'd3;
        else if (mag_reg <= mast_pkg::MAG_W'(mast_pkg::ACCEL_T3))  accel = 3'd2;
        else                                                       accel = 3'd1;
    end

    // Time products: error times stroke time, then times acceleration into the divider
    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            prod1_reg <= mast_pkg::PROD1_W'(mag_reg) * mast_pkg::PROD1_W'(stroke_time_reg);
        end
    end

    assign dividend = mast_pkg::PROD_W'(prod1_reg) * mast_pkg::PROD_W'(accel);
    assign divisor  = (stroke_steps_reg == '0) ? mast_pkg::CFG_W'(1) : stroke_steps_reg;

    mast_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .last     (div_last)
    );

    // Update step: move end, sync window and timeout
    always_comb begin
        past       = now_reg - deadline_reg;
        since_sync = now_reg - last_sync_reg;
        moving_upd = moving_reg && !(past != '0 && !past[mast_pkg::TIME_W-1]);
        in_window  = mast_pkg::CMP_W'(mag_reg) < mast_pkg::CMP_W'(sync_window_reg);
        sync_upd   = sync_reg;
        event_upd  = 1'b0;
        if (in_window) begin
            sync_upd = 1'b1;
        end else if (since_sync >= mast_pkg::TIME_W'(sync_timeout_reg)
                     && sync_reg && !moving_upd) begin
            sync_upd  = 1'b0;
            event_upd = enable_reg;
        end
    end

    // Setpoint: clamp and halve toward zero
    always_comb begin
        priority if (cmd_val_reg < mast_pkg::SETPOINT_MIN) clamped = mast_pkg::SETPOINT_MIN;
        else if (cmd_val_reg > mast_pkg::SETPOINT_MAX)     clamped = mast_pkg::SETPOINT_MAX;
        else                                               clamped = cmd_val_reg;
        clamp_adj = clamped + {{(mast_pkg::CMD_W-1){1'b0}}, clamped[mast_pkg::CMD_W-1]};
        setpoint  = clamp_adj[mast_pkg::TGT_W:1];
    end

    // Axis state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg      <= '0;
            prev_target_reg <= '0;
            moving_reg      <= 1'b0;
            deadline_reg    <= '0;
            last_sync_reg   <= '0;
            sync_reg        <= 1'b1;
            enable_reg      <= 1'b0;
        end else if (cmd.deadline) begin
            deadline_reg    <= now_reg + mast_pkg::TIME_W'(quotient);
            prev_target_reg <= target_reg;
            moving_reg      <= 1'b1;
        end else if (cmd.commit) begin
            // Unused function code leaves the state alone
            unique case (func_reg)
                mast_pkg::FUNC_UPDATE: begin
                    moving_reg <= moving_upd;
                    sync_reg   <= sync_upd;
                    if (in_window) last_sync_reg <= now_reg;
                end
                mast_pkg::FUNC_SETPOINT: target_reg <= setpoint;
                mast_pkg::FUNC_POWER:    enable_reg <= (cmd_val_reg == '0);
                default: ;
            endcase
        end
    end

    // Output word payload
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (func_reg == mast_pkg::FUNC_UPDATE) begin
                out_step_reg   <= step_reg;
                out_motion_reg <= moving_upd;
                out_sync_reg   <= sync_upd;
                out_event_reg  <= event_upd;
            end else begin
                out_step_reg   <= '0;
                out_motion_reg <= moving_reg;
                out_sync_reg   <= sync_reg;
                out_event_reg  <= 1'b0;
            end
            out_enable_reg <= (func_reg == mast_pkg::FUNC_POWER) ? (cmd_val_reg == '0)
                                                                 : enable_reg;
        end
    end

    // Output valid: set on commit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        stat.move_needed = (func_reg == mast_pkg::FUNC_UPDATE)
                           && (prev_target_reg != target_reg);
        stat.div_last    = div_last;
        stat.out_free    = !out_valid_reg || m_ready;
    end

    assign m_valid             = out_valid_reg;
    assign m_step_relative     = out_step_reg;
    assign m_in_motion         = out_motion_reg;
    assign m_synchronized      = out_sync_reg;
    assign m_out_of_sync_event = out_event_reg;
    assign m_drive_enable      = out_enable_reg;

endmodule

/* rtl/motor_axis_sync_tracker_core.sv */
// Top level of the motor axis sync tracker: controller plus datapath.
// Depends on mast_pkg, mast_ctrl, mast_dp (which holds mast_div).
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    func, position_sample, now_ms, command_value
//   m_       out        m_valid / m_ready    step_relative, in_motion, synchronized,
//                                            out_of_sync_event, drive_enable
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One word at a time. Commands and updates without a setpoint change pass
// IDLE, CALC and FINISH; an update after a setpoint change also passes MUL1,
// MUL2, DIV (the bit-serial divider) and DEADLINE. FINISH waits for a free output register.
// Synchronous active-low reset; no clearing pass. A stalled result sits in
// the output register while the next word is accepted and processed.
module motor_axis_sync_tracker_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mast_pkg::FUNC_W-1:0]          s_func,
    input  logic [mast_pkg::SAMPLE_BITS-1:0]     s_position_sample,
    input  logic [mast_pkg::TIME_W-1:0]          s_now_ms,
    input  logic signed [mast_pkg::CMD_W-1:0]    s_command_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mast_pkg::STEP_W-1:0]   m_step_relative,
    output logic                                 m_in_motion,
    output logic                                 m_synchronized,
    output logic                                 m_out_of_sync_event,
    output logic                                 m_drive_enable,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mast_pkg::IDX_W-1:0]           cfg_index,
    input  logic [mast_pkg::CFG_W-1:0]           cfg_data
);

    mast_pkg::mast_cmd_t  cmd;
    mast_pkg::mast_stat_t stat;

    // Configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    mast_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mast_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_func              (s_func),
        .s_position_sample   (s_position_sample),
        .s_now_ms            (s_now_ms),
        .s_command_value     (s_command_value),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_step_relative     (m_step_relative),
        .m_in_motion         (m_in_motion),
        .m_synchronized      (m_synchronized),
        .m_out_of_sync_event (m_out_of_sync_event),
        .m_drive_enable      (m_drive_enable)
    );

endmodule

/* rtl/mast_checker.sv */
// Port-level checks for the motor axis sync tracker, bound to the top level.
// Depends on mast_pkg and motor_axis_sync_tracker_core.
module mast_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [mast_pkg::STEP_W-1:0]   m_step_relative,
    input logic                                 m_in_motion,
    input logic                                 m_synchronized,
    input logic                                 m_out_of_sync_event,
    input logic                                 m_drive_enable
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_step_relative)
            && $stable(m_synchronized) && $stable(m_out_of_sync_event))
        else $error("stalled result word changed");

    // Sync-loss event only while enabled, stopped and now out of sync
    a_event_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_sync_event |-> !m_synchronized && !m_in_motion && m_drive_enable)
        else $error("out-of-sync event with inconsistent status");

    // Half error stays within the sensor span
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_step_relative >= -10'sd506) && (m_step_relative <= 10'sd506))
        else $error("step command out of range");

    // One word in flight: no accept on the cycle after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in process");

endmodule

bind motor_axis_sync_tracker_core mast_checker u_mast_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_step_relative     (m_step_relative),
    .m_in_motion         (m_in_motion),
    .m_synchronized      (m_synchronized),
    .m_out_of_sync_event (m_out_of_sync_event),
    .m_drive_enable      (m_drive_enable)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for motor_axis_sync_tracker_core: directed and random words
// checked against an in-bench status predictor. Depends on mast_pkg and the RTL only.
module tb;

    localparam logic [mast_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_WORDS  = 1330;
    localparam int PHASES        = 7;

    typedef struct {
        logic [mast_pkg::FUNC_W-1:0]        func;
        logic [mast_pkg::SAMPLE_BITS-1:0]   sample;
        logic [mast_pkg::TIME_W-1:0]        now_ms;
        logic signed [mast_pkg::CMD_W-1:0]  cmd;
    } axis_word_t;

    typedef struct {
        logic signed [mast_pkg::STEP_W-1:0] step;
        logic                               motion;
        logic                               sync;
        logic                               oos;
        logic                               enable;
    } axis_status_t;

    typedef struct {
        logic [mast_pkg::CFG_W-1:0] stroke_ms;
        logic [mast_pkg::CFG_W-1:0] stroke_steps;
        logic [mast_pkg::CFG_W-1:0] window;
        logic [mast_pkg::CFG_W-1:0] timeout;
    } reg_set_t;

    typedef enum int {RDY_OPEN, RDY_COIN, RDY_PERIODIC, RDY_HOLD} ready_mode_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [mast_pkg::FUNC_W-1:0]          s_func;
    logic [mast_pkg::SAMPLE_BITS-1:0]     s_position_sample;
    logic [mast_pkg::TIME_W-1:0]          s_now_ms;
    logic signed [mast_pkg::CMD_W-1:0]    s_command_value;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [mast_pkg::STEP_W-1:0]   m_step_relative;
    logic                                 m_in_motion;
    logic                                 m_synchronized;
    logic                                 m_out_of_sync_event;
    logic                                 m_drive_enable;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [mast_pkg::IDX_W-1:0]           cfg_index;
    logic [mast_pkg::CFG_W-1:0]           cfg_data;

    // Predictor copy of the registers and of the tracker state
    logic [mast_pkg::CFG_W-1:0]           cfg_stroke_ms;
    logic [mast_pkg::CFG_W-1:0]           cfg_stroke_steps;
    logic [mast_pkg::WIN_W-1:0]           cfg_window;
    logic [mast_pkg::CFG_W-1:0]           cfg_timeout;
    int                                   tgt_pos;
    int                                   prev_tgt;
    logic                                 moving;
    logic [mast_pkg::TIME_W-1:0]          deadline;
    logic [mast_pkg::TIME_W-1:0]          last_in_window;
    logic                                 in_sync;
    logic                                 drive_on;

    axis_status_t                         status_q[$];
    axis_word_t                           word_q[$];
    int                                   mismatches;
    int                                   idle_cycles;
    int                                   burst_left;
    int                                   plan_tgt;
    logic [mast_pkg::TIME_W-1:0]          ms_now;

    motor_axis_sync_tracker_core dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_func              (s_func),
        .s_position_sample   (s_position_sample),
        .s_now_ms            (s_now_ms),
        .s_command_value     (s_command_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_step_relative     (m_step_relative),
        .m_in_motion         (m_in_motion),
        .m_synchronized      (m_synchronized),
        .m_out_of_sync_event (m_out_of_sync_event),
        .m_drive_enable      (m_drive_enable),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Return tracker state and registers to their power-up values
    function automatic void reset_model();
        cfg_stroke_ms    = mast_pkg::RST_STROKE_TIME;
        cfg_stroke_steps = mast_pkg::RST_STROKE_STEPS;
        cfg_window       = mast_pkg::RST_SYNC_WINDOW;
        cfg_timeout      = mast_pkg::RST_SYNC_TIMEOUT;
        tgt_pos          = 0;
        prev_tgt         = 0;
        moving           = 1'b0;
        deadline         = '0;
        last_in_window   = '0;
        in_sync          = 1'b1;
        drive_on         = 1'b0;
    endfunction

    function automatic void set_model_reg(logic [mast_pkg::IDX_W-1:0] idx,
                                          logic [mast_pkg::CFG_W-1:0] data);
        case (idx)
            mast_pkg::REG_STROKE_TIME:  cfg_stroke_ms    = data;
            mast_pkg::REG_STROKE_STEPS: cfg_stroke_steps = data;
            mast_pkg::REG_SYNC_WINDOW:  cfg_window       = data[mast_pkg::WIN_W-1:0];
            mast_pkg::REG_SYNC_TIMEOUT: cfg_timeout      = data;
            default: ;
        endcase
    endfunction

    // Advance the tracker by one word and return the status it reports
    function automatic axis_status_t axis_status(axis_word_t w);
        axis_status_t st;
        int actual;
        int err;
        int mag;
        int accel;
        int clamped;
        longint travel_ms;
        longint divisor;
        logic [mast_pkg::TIME_W-1:0] past;
        logic [mast_pkg::TIME_W-1:0] elapsed;
        st.step = '0;
        st.oos  = 1'b0;
        case (w.func)
            mast_pkg::FUNC_UPDATE: begin
                actual  = int'(w.sample) - mast_pkg::SAMPLE_HALF;
                err     = tgt_pos - actual;
                mag     = (err < 0) ? -err : err;
                st.step = mast_pkg::STEP_W'(err / 2);
                // New setpoint: estimate when the move ends
                if (prev_tgt != tgt_pos) begin
                    accel     = 1 + (mast_pkg::ACCEL_BASE - mag) / mast_pkg::ACCEL_SPAN;
                    divisor   = (cfg_stroke_steps == 0) ? 64'sd1 : longint'(cfg_stroke_steps);
                    travel_ms = (longint'(mag) * longint'(cfg_stroke_ms) * longint'(accel))
                                / divisor;
                    prev_tgt  = tgt_pos;
                    moving    = 1'b1;
                    deadline  = w.now_ms + travel_ms[mast_pkg::TIME_W-1:0];
                end
                // Move is over once now is strictly past the deadline, modulo 2^32
                past = w.now_ms - deadline;
                if (moving && past != 0 && !past[mast_pkg::TIME_W-1])
                    moving = 1'b0;
                elapsed = w.now_ms - last_in_window;
                if (mag < int'(cfg_window)) begin
                    in_sync        = 1'b1;
                    last_in_window = w.now_ms;
                end else if (elapsed >= mast_pkg::TIME_W'(cfg_timeout) && in_sync
                             && !moving) begin
                    in_sync = 1'b0;
                    st.oos  = drive_on;
                end
            end
            mast_pkg::FUNC_SETPOINT: begin
                clamped = int'(w.cmd);
                if (clamped < int'(mast_pkg::SETPOINT_MIN)) clamped = int'(mast_pkg::SETPOINT_MIN);
                if (clamped > int'(mast_pkg::SETPOINT_MAX)) clamped = int'(mast_pkg::SETPOINT_MAX);
                tgt_pos = clamped / 2;
            end
            mast_pkg::FUNC_POWER: begin
                drive_on = (w.cmd == 0);
            end
            default: ;
        endcase
        st.motion = moving;
        st.sync   = in_sync;
        st.enable = drive_on;
        return st;
    endfunction

    function automatic void log_mismatch(string msg);
        if (mismatches < 10)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endfunction

    // Queue one word; track the setpoint so random samples can follow it
    function automatic void queue_word(logic [mast_pkg::FUNC_W-1:0] func,
                                       logic [mast_pkg::SAMPLE_BITS-1:0] sample,
                                       logic [mast_pkg::TIME_W-1:0] now,
                                       logic signed [mast_pkg::CMD_W-1:0] cmd);
        axis_word_t w;
        int v;
        w.func   = func;
        w.sample = sample;
        w.now_ms = now;
        w.cmd    = cmd;
        word_q.push_back(w);
        if (func == mast_pkg::FUNC_SETPOINT) begin
            v = int'(cmd);
            if (v < int'(mast_pkg::SETPOINT_MIN)) v = int'(mast_pkg::SETPOINT_MIN);
            if (v > int'(mast_pkg::SETPOINT_MAX)) v = int'(mast_pkg::SETPOINT_MAX);
            plan_tgt = v / 2;
        end
    endfunction

    // Mostly small forward steps, some long waits, a few arbitrary jumps
    function automatic logic [mast_pkg::TIME_W-1:0] next_ms();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r >= 97)
            ms_now += $urandom;
        else if (r >= 85)
            ms_now += $urandom_range(200, 5000);
        else if (r >= 10)
            ms_now += $urandom_range(1, 120);
        return ms_now;
    endfunction

    // Optional command, then a run of updates that hold near, off or away from target
    function automatic int queue_episode();
        int made;
        int n;
        int mode;
        int held;
        int off;
        int s;
        int r;
        made = 0;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            queue_word(mast_pkg::FUNC_POWER, mast_pkg::SAMPLE_BITS'($urandom), next_ms(),
                       ($urandom_range(0, 2) == 0) ? mast_pkg::CMD_W'($urandom) : '0);
            made++;
        end else if (r < 55) begin
            queue_word(mast_pkg::FUNC_SETPOINT, mast_pkg::SAMPLE_BITS'($urandom), next_ms(),
                       ($urandom_range(0, 3) == 0)
                           ? mast_pkg::CMD_W'($urandom)
                           : mast_pkg::CMD_W'(int'($urandom_range(0, 2400)) - 1200));
            made++;
        end
        if ($urandom_range(0, 29) == 0)
            queue_word(FUNC_UNUSED, mast_pkg::SAMPLE_BITS'($urandom), $urandom,
                       mast_pkg::CMD_W'($urandom));
        n    = $urandom_range(3, 30);
        mode = $urandom_range(0, 3);
        held = int'($urandom_range(25, 700)) * (($urandom_range(0, 1) == 0) ? 1 : -1);
        for (int k = 0; k < n; k++) begin
            if (mode == 0 || (mode == 3 && k < n / 2))
                off = int'($urandom_range(0, 30)) - 15;
            else
                off = held + int'($urandom_range(0, 6)) - 3;
            s = mast_pkg::SAMPLE_HALF + plan_tgt + off;
            if (s < 0) s = 0;
            if (s > 1023) s = 1023;
            if (mode == 2)
                s = $urandom_range(0, 1023);
            queue_word(mast_pkg::FUNC_UPDATE, mast_pkg::SAMPLE_BITS'(s), next_ms(),
                       mast_pkg::CMD_W'($urandom));
        end
        return made + n;
    endfunction

    // Wait for every expected status, then let the block go quiet
    task automatic settle_block();
        while (status_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Play the word queue in bursts with random gaps, then drain
    task automatic run_words();
        axis_word_t w;
        int gap;
        while (word_q.size() != 0) begin
            w = word_q.pop_front();
            @(negedge aclk);
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst_left--;
            s_valid           <= 1'b1;
            s_func            <= w.func;
            s_position_sample <= w.sample;
            s_now_ms          <= w.now_ms;
            s_command_value   <= w.cmd;
            do @(posedge aclk); while (!s_ready);
            status_q.push_back(axis_status(w));
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        settle_block();
    endtask

    task automatic write_reg(logic [mast_pkg::IDX_W-1:0] idx, logic [mast_pkg::CFG_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        set_model_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_reg_set(reg_set_t r);
        write_reg(mast_pkg::REG_STROKE_TIME, r.stroke_ms);
        write_reg(mast_pkg::REG_STROKE_STEPS, r.stroke_steps);
        write_reg(mast_pkg::REG_SYNC_WINDOW, r.window);
        write_reg(mast_pkg::REG_SYNC_TIMEOUT, r.timeout);
    endtask

    // Field extremes, the unused function code, setpoint clamping, power save
    task automatic test_field_extremes();
        queue_word(mast_pkg::FUNC_UPDATE, 10'd512, 32'd0, 16'sd0);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd0, 32'hFFFF_FFFF, -16'sd32768);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd1023, 32'd5, 16'sd32767);
        queue_word(FUNC_UNUSED, 10'd1023, 32'hFFFF_FFFF, -16'sd1);
        queue_word(mast_pkg::FUNC_SETPOINT, 10'd0, 32'd6, 16'sd32767);
        queue_word(mast_pkg::FUNC_SETPOINT, 10'd0, 32'd7, -16'sd32768);
        queue_word(mast_pkg::FUNC_SETPOINT, 10'd0, 32'd8, 16'sd1001);
        queue_word(mast_pkg::FUNC_SETPOINT, 10'd0, 32'd9, -16'sd999);
        queue_word(mast_pkg::FUNC_POWER, 10'd0, 32'd10, 16'sd0);
        queue_word(mast_pkg::FUNC_POWER, 10'd0, 32'd11, -16'sd1);
        queue_word(mast_pkg::FUNC_POWER, 10'd0, 32'd12, 16'sd0);
        run_words();
    endtask

    // Zero-length and large-error moves, deadline near the sign boundary,
    // loss of sync with its one-shot event, and recovery
    task automatic test_move_and_sync();
        logic [mast_pkg::TIME_W-1:0] t0;
        t0 = 32'h7FFF_FF00;
        queue_word(mast_pkg::FUNC_SETPOINT, 10'd0, t0, 16'sd0);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd512, t0, 16'sd0);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd512, t0 + 1, 16'sd0);
        queue_word(mast_pkg::FUNC_SETPOINT, 10'd0, t0 + 1, 16'sd1000);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd0, t0 + 2, 16'sd0);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd1023, t0 + 3375, 16'sd0);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd0, t0 + 5000, 16'sd0);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd0, t0 + 7000, 16'sd0);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd1012, t0 + 7001, 16'sd0);
        queue_word(mast_pkg::FUNC_UPDATE, 10'd300, t0 + 9000, 16'sd0);
        run_words();
    endtask

    // Random episodes under a series of register settings, extremes included
    task automatic test_config_sweep();
        reg_set_t sets[PHASES];
        int made;
        sets = '{
            '{16'd3000, 16'd900, 16'd20, 16'd1000},
            '{16'd65535, 16'd1, 16'h03FF, 16'd0},
            '{16'd0, 16'd0, 16'h0000, 16'd65535},
            '{16'd1500, 16'd65535, 16'hFC28, 16'd50},
            '{16'd0, 16'd0, 16'd0, 16'd0},
            '{16'd3000, 16'd900, 16'd20, 16'd1000},
            '{16'd400, 16'd120, 16'd1, 16'd1}
        };
        for (int p = 0; p < PHASES; p++) begin
            // Phase zero runs on the reset values
            if (p == 4) begin
                sets[p].stroke_ms    = mast_pkg::CFG_W'($urandom_range(0, 65535));
                sets[p].stroke_steps = mast_pkg::CFG_W'($urandom_range(0, 65535));
                sets[p].window       = mast_pkg::CFG_W'($urandom_range(1, 1023));
                sets[p].timeout      = mast_pkg::CFG_W'($urandom_range(0, 3000));
            end
            if (p > 0)
                write_reg_set(sets[p]);
            made = 0;
            while (made < RANDOM_WORDS / PHASES)
                made += queue_episode();
            run_words();
        end
    endtask

    // Receiver: stretches of always-ready, coin-flip, periodic and held-off
    initial begin
        ready_mode_t mode;
        int span;
        int period;
        m_ready = 1'b0;
        forever begin
            mode   = ready_mode_t'($urandom_range(0, 3));
            span   = $urandom_range(8, 80);
            period = $urandom_range(2, 6);
            for (int c = 0; c < span; c++) begin
                @(negedge aclk);
                case (mode)
                    RDY_OPEN:     m_ready <= 1'b1;
                    RDY_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RDY_PERIODIC: m_ready <= (c % period == 0);
                    default:      m_ready <= 1'b0;
                endcase
            end
        end
    end

    // Compare each delivered word with the oldest expected status
    always @(posedge aclk) begin
        axis_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                log_mismatch("result word with no status expected");
            end else begin
                want = status_q.pop_front();
                if (m_step_relative !== want.step || m_in_motion !== want.motion
                    || m_synchronized !== want.sync || m_out_of_sync_event !== want.oos
                    || m_drive_enable !== want.enable)
                    log_mismatch($sformatf({"status mismatch: exp step %0d mot %b sync %b ",
                        "evt %b en %b, got step %0d mot %b sync %b evt %b en %b"},
                        want.step, want.motion, want.sync, want.oos, want.enable,
                        m_step_relative, m_in_motion, m_synchronized,
                        m_out_of_sync_event, m_drive_enable));
            end
        end
    end

    // Watchdog: end the run when no channel moves a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_func            = mast_pkg::FUNC_UPDATE;
        s_position_sample = '0;
        s_now_ms          = '0;
        s_command_value   = '0;
        cfg_valid         = 1'b0;
        cfg_index         = mast_pkg::REG_STROKE_TIME;
        cfg_data          = '0;
        mismatches        = 0;
        burst_left        = 0;
        plan_tgt          = 0;
        ms_now            = $urandom;
        reset_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_move_and_sync();
        test_config_sweep();

        if (status_q.size() != 0)
            log_mismatch("expected status words never delivered");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
